// ===== hw/rtl/c8ie_pkg.sv =====
// Shared types, opcode constants and a helper function for the CHIP-8 execute core.
`timescale 1ns / 1ps
`default_nettype none

package c8ie_pkg;

    localparam int MEM_BYTES_DEF   = 4096;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int DISPLAY_PIXELS  = 2048;
    localparam int FRAME_BYTES     = DISPLAY_PIXELS / 8;
    localparam int FRAME_AW        = $clog2(FRAME_BYTES);
    localparam int NUM_GP          = 16;

    localparam logic [11:0] PC_RESET  = 12'h200;
    localparam logic [11:0] NNN_CLS   = 12'h0E0;
    localparam logic [11:0] NNN_RET   = 12'h0EE;
    localparam logic [15:0] FONT_BASE = 16'h0050;
    localparam logic [3:0]  FLAG_REG  = 4'hF;

    // Major opcode nibble.
    localparam logic [3:0] OP_SYS   = 4'h0;
    localparam logic [3:0] OP_JP    = 4'h1;
    localparam logic [3:0] OP_CALL  = 4'h2;
    localparam logic [3:0] OP_SE_K  = 4'h3;
    localparam logic [3:0] OP_SNE_K = 4'h4;
    localparam logic [3:0] OP_SE_V  = 4'h5;
    localparam logic [3:0] OP_LD_K  = 4'h6;
    localparam logic [3:0] OP_ADD_K = 4'h7;
    localparam logic [3:0] OP_ALU   = 4'h8;
    localparam logic [3:0] OP_SNE_V = 4'h9;
    localparam logic [3:0] OP_LD_I  = 4'hA;
    localparam logic [3:0] OP_JP_V0 = 4'hB;
    localparam logic [3:0] OP_RND   = 4'hC;
    localparam logic [3:0] OP_DRW   = 4'hD;
    localparam logic [3:0] OP_KEY   = 4'hE;
    localparam logic [3:0] OP_MISC  = 4'hF;

    // Register-to-register subcodes of 8xyN.
    localparam logic [3:0] N_MOV  = 4'h0;
    localparam logic [3:0] N_OR   = 4'h1;
    localparam logic [3:0] N_AND  = 4'h2;
    localparam logic [3:0] N_XOR  = 4'h3;
    localparam logic [3:0] N_ADD  = 4'h4;
    localparam logic [3:0] N_SUB  = 4'h5;
    localparam logic [3:0] N_SHR  = 4'h6;
    localparam logic [3:0] N_RSUB = 4'h7;
    localparam logic [3:0] N_SHL  = 4'hE;

    // Fxkk subcodes.
    localparam logic [7:0] FX_GET_DT = 8'h07;
    localparam logic [7:0] FX_SET_DT = 8'h15;
    localparam logic [7:0] FX_SET_ST = 8'h18;
    localparam logic [7:0] FX_ADD_I  = 8'h1E;
    localparam logic [7:0] FX_FONT   = 8'h29;
    localparam logic [7:0] FX_BCD    = 8'h33;
    localparam logic [7:0] FX_STORE  = 8'h55;
    localparam logic [7:0] FX_LOAD   = 8'h65;

    typedef enum logic [1:0] {
        KIND_EXEC   = 2'd0,
        KIND_MWRITE = 2'd1,
        KIND_FREAD  = 2'd2,
        KIND_BAD    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNSUP = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ALU_PASS,
        ALU_OR,
        ALU_AND,
        ALU_XOR,
        ALU_ADD,
        ALU_SUB,
        ALU_RSUB,
        ALU_SHR,
        ALU_SHL
    } alu_op_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_RDX,
        S_RDY,
        S_LATY,
        S_DECODE,
        S_POP,
        S_VFLAG,
        S_IMOD,
        S_BCD,
        S_ST_RD,
        S_ST_WR,
        S_LD_RD,
        S_LD_WR,
        S_D_RD,
        S_D_LINE,
        S_D_A,
        S_D_BR,
        S_D_B,
        S_FCLR,
        S_MWR,
        S_FRD,
        S_FRD_WAIT,
        S_FIN_F,
        S_FIN_X,
        S_FIN_W,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] opcode;
        logic [7:0]  random_byte;
        logic [11:0] address;
        logic [7:0]  write_data;
    } in_item_t;

    typedef struct packed {
        logic [11:0] program_counter;
        logic [15:0] index_value;
        logic [7:0]  flag_value;
        logic [7:0]  target_value;
        logic [7:0]  delay_value;
        logic [7:0]  sound_value;
        logic [4:0]  stack_level;
        logic [7:0]  read_data;
        logic [1:0]  status;
    } out_item_t;

    // Decimal digit of an 8-bit value: sel 0 hundreds, 1 tens, 2 units.
    // Tens use a reciprocal multiply that is exact below one hundred.
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
        logic [1:0]  hund;
        logic [7:0]  rest;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        if (v >= 8'd200) begin
            hund = 2'd2;
            rest = v - 8'd200;
        end else if (v >= 8'd100) begin
            hund = 2'd1;
            rest = v - 8'd100;
        end else begin
            hund = 2'd0;
            rest = v;
        end
        prod  = 15'(rest[6:0]) * 15'd205;
        tens  = prod[14:11];
        units = rest[6:0] - (7'(tens) * 7'd10);
        case (sel)
            2'd0:    bcd_digit = {6'b0, hund};
            2'd1:    bcd_digit = {4'b0, tens};
            default: bcd_digit = {1'b0, units};
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/c8ie_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module c8ie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    wa,
    input  wire logic [WIDTH-1:0] wd,
    input  wire logic [AW-1:0]    ra,
    output logic      [WIDTH-1:0] rd
);

    logic [WIDTH-1:0] mem_array [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem_array[wa] <= wd;
        end
        rd <= mem_array[ra];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/c8ie_alu.sv =====
// Shared 8-bit arithmetic, logic and shift unit of the execute core.
`timescale 1ns / 1ps
`default_nettype none

module c8ie_alu
    import c8ie_pkg::*;
(
    input  wire alu_op_t    op,
    input  wire logic [7:0] a,
    input  wire logic [7:0] b,
    output logic      [7:0] y,
    output logic            flag
);

    logic [8:0] sum;
    logic [8:0] dif;
    logic [8:0] rdif;

    assign sum  = {1'b0, a} + {1'b0, b};
    assign dif  = {1'b0, a} - {1'b0, b};
    assign rdif = {1'b0, b} - {1'b0, a};

    always_comb begin
        y    = b;
        flag = 1'b0;
        unique case (op)
            ALU_PASS: y = b;
            ALU_OR:   y = a | b;
            ALU_AND:  y = a & b;
            ALU_XOR:  y = a ^ b;
            ALU_ADD: begin
                y    = sum[7:0];
                flag = sum[8];
            end
            ALU_SUB: begin
                y    = dif[7:0];
                flag = ~dif[8];
            end
            ALU_RSUB: begin
                y    = rdif[7:0];
                flag = ~rdif[8];
            end
            ALU_SHR: begin
                y    = {1'b0, a[7:1]};
                flag = a[0];
            end
            ALU_SHL: begin
                y    = {a[6:0], 1'b0};
                flag = a[7];
            end
            default: y = b;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/chip8_instruction_execute_core.sv =====
// Top level of the CHIP-8 instruction execute core: sequencer, state registers and memories.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  in_item_t  (kind, opcode, random_byte, address,
//                                                     write_data)
// m_        out        m_valid / m_ready  out_item_t (visible state after the item)
//
// One item is in flight at a time. A simple instruction passes through acceptance,
// two register file reads, decode, then two reads that fetch VF and Vx for the result.
// An 8xyN that sets the flag adds the VF write. Fx55 and Fx65 read and then write each
// byte in turn and Fx33 writes each digit in turn, after I is reduced into the memory
// range; Dxyn reads each sprite row and updates one display byte, or two when the row
// is not byte aligned; 00E0 clears one display byte per cycle. The register file and
// display RAM, each with one read port and registered read data, set this sequencing.
// After reset the core sweeps the memory to zero it, the display and the registers, and
// holds s_ready low meanwhile. A finished result sits in an output register; a new item is
// taken while it waits, and only the next result stalls until m_ready frees that register.
module chip8_instruction_execute_core
    import c8ie_pkg::*;
#(
    parameter int MEM_BYTES   = MEM_BYTES_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    localparam int AW  = $clog2(MEM_BYTES);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam logic [16:0] MEMW = 17'(MEM_BYTES);

    // Control state.
    state_t          state_reg, state_next;
    logic [11:0]     pc_reg, pc_next;
    logic [15:0]     i_reg, i_next;
    logic [SPW-1:0]  sp_reg, sp_next;
    logic [7:0]      dt_reg, dt_next;
    logic [7:0]      st_reg, st_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic            m_valid_reg, m_valid_next;

    // Working registers of the current item.
    in_item_t        item_reg, item_next;
    logic [7:0]      vx_reg, vx_next;
    logic [7:0]      vy_reg, vy_next;
    logic [7:0]      line_reg, line_next;
    logic [7:0]      flagv_reg, flagv_next;
    logic [7:0]      tgt_reg, tgt_next;
    logic [7:0]      rdata_reg, rdata_next;
    logic [16:0]     base_reg, base_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic            hit_reg, hit_next;
    logic            aflag_reg, aflag_next;
    status_t         status_reg, status_next;
    out_item_t       res_reg, res_next;

    // Opcode fields.
    logic [3:0]  op_hi, fx, fy, fn;
    logic [7:0]  kk;
    logic [11:0] nnn;

    // RAM ports.
    logic                gp_we;
    logic [3:0]          gp_wa, gp_ra;
    logic [7:0]          gp_wd, gp_rd;
    logic                stk_we;
    logic [SAW-1:0]      stk_wa, stk_ra;
    logic [11:0]         stk_wd, stk_rd;
    logic                mem_we;
    logic [AW-1:0]       mem_wa, mem_ra;
    logic [7:0]          mem_wd, mem_rd;
    logic                frm_we;
    logic [FRAME_AW-1:0] frm_wa, frm_ra;
    logic [7:0]          frm_wd, frm_rd;

    // Shared ALU.
    alu_op_t    alu_op;
    logic [7:0] alu_a, alu_b, alu_y;
    logic       alu_flag;

    // Helpers.
    logic [11:0]         pc_inc, pc_skip;
    logic [SPW-1:0]      sp_dec;
    logic                stack_full, stack_empty;
    logic                is_cls, is_ret, alu_ok, alu_sets_flag;
    logic [16:0]         addr_sum, addr_off;
    logic [AW-1:0]       mem_addr;
    logic [7:0]          py_sum;
    logic [FRAME_AW-1:0] byte_a, byte_b;
    logic [15:0]         sprite_wide;
    logic [7:0]          frm_mask;
    logic                hit_now, row_last, loop_last;

    assign op_hi = item_reg.opcode[15:12];
    assign fx    = item_reg.opcode[11:8];
    assign fy    = item_reg.opcode[7:4];
    assign fn    = item_reg.opcode[3:0];
    assign kk    = item_reg.opcode[7:0];
    assign nnn   = item_reg.opcode[11:0];

    assign pc_inc      = pc_reg + 12'd2;
    assign pc_skip     = pc_reg + 12'd4;
    assign sp_dec      = sp_reg - SPW'(1);
    assign stack_full  = (sp_reg >= SPW'(STACK_DEPTH));
    assign stack_empty = (sp_reg == '0);
    assign is_cls      = (nnn == NNN_CLS);
    assign is_ret      = (nnn == NNN_RET);
    assign alu_sets_flag = (fn == N_ADD) || (fn == N_SUB) || (fn == N_SHR) ||
                           (fn == N_RSUB) || (fn == N_SHL);
    assign alu_ok        = alu_sets_flag || (fn == N_MOV) || (fn == N_OR) ||
                           (fn == N_AND) || (fn == N_XOR);

    // Memory address I + offset, with I already reduced below MEM_BYTES.
    assign addr_sum = base_reg + {13'b0, cnt_reg};
    assign addr_off = (addr_sum >= MEMW) ? (addr_sum - MEMW) : addr_sum;
    assign mem_addr = addr_off[AW-1:0];

    // Sprite geometry: a row of eight pixels covers at most two display bytes
    // of the same screen line, the second one wrapping around horizontally.
    assign py_sum      = vy_reg + {4'b0, cnt_reg};
    assign byte_a      = {py_sum[4:0], vx_reg[5:3]};
    assign byte_b      = {py_sum[4:0], vx_reg[5:3] + 3'd1};
    assign sprite_wide = {line_reg, 8'h00} >> vx_reg[2:0];
    assign frm_mask    = (state_reg == S_D_B) ? sprite_wide[7:0] : sprite_wide[15:8];
    assign hit_now     = hit_reg | (|(frm_rd & frm_mask));
    assign row_last    = (cnt_reg == (fn - 4'd1));
    assign loop_last   = (cnt_reg == fx);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = res_reg;

    c8ie_ram #(.WIDTH(8), .DEPTH(NUM_GP)) u_gp_ram (
        .clk(aclk), .we(gp_we), .wa(gp_wa), .wd(gp_wd), .ra(gp_ra), .rd(gp_rd)
    );

    c8ie_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .clk(aclk), .we(stk_we), .wa(stk_wa), .wd(stk_wd), .ra(stk_ra), .rd(stk_rd)
    );

    c8ie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_main_ram (
        .clk(aclk), .we(mem_we), .wa(mem_wa), .wd(mem_wd), .ra(mem_ra), .rd(mem_rd)
    );

    c8ie_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_ram (
        .clk(aclk), .we(frm_we), .wa(frm_wa), .wd(frm_wd), .ra(frm_ra), .rd(frm_rd)
    );

    c8ie_alu u_alu (
        .op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y), .flag(alu_flag)
    );

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_reg == AW'(MEM_BYTES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    unique case (kind_t'(s_data.kind))
                        KIND_EXEC:   state_next = S_RDX;
                        KIND_MWRITE: state_next = S_MWR;
                        KIND_FREAD:  state_next = S_FRD;
                        default:     state_next = S_FIN_F;
                    endcase
                end
            end
            S_RDX:  state_next = S_RDY;
            S_RDY:  state_next = S_LATY;
            S_LATY: state_next = S_DECODE;
            S_DECODE: begin
                unique case (op_hi)
                    OP_SYS: begin
                        if (is_cls) begin
                            state_next = S_FCLR;
                        end else if (is_ret && !stack_empty) begin
                            state_next = S_POP;
                        end else begin
                            state_next = S_FIN_F;
                        end
                    end
                    OP_ALU: state_next = (alu_ok && alu_sets_flag) ? S_VFLAG : S_FIN_F;
                    OP_DRW: state_next = (fn == 4'd0) ? S_VFLAG : S_IMOD;
                    OP_MISC: begin
                        case (kk) inside
                            FX_BCD, FX_STORE, FX_LOAD: state_next = S_IMOD;
                            default:                   state_next = S_FIN_F;
                        endcase
                    end
                    default: state_next = S_FIN_F;
                endcase
            end
            S_POP:   state_next = S_FIN_F;
            S_VFLAG: state_next = S_FIN_F;
            S_IMOD: begin
                if (base_reg < MEMW) begin
                    if (op_hi == OP_DRW) begin
                        state_next = S_D_RD;
                    end else if (kk == FX_BCD) begin
                        state_next = S_BCD;
                    end else if (kk == FX_STORE) begin
                        state_next = S_ST_RD;
                    end else begin
                        state_next = S_LD_RD;
                    end
                end
            end
            S_BCD: begin
                if (cnt_reg == 4'd2) begin
                    state_next = S_FIN_F;
                end
            end
            S_ST_RD: state_next = S_ST_WR;
            S_ST_WR: state_next = loop_last ? S_FIN_F : S_ST_RD;
            S_LD_RD: state_next = S_LD_WR;
            S_LD_WR: state_next = loop_last ? S_FIN_F : S_LD_RD;
            S_D_RD:   state_next = S_D_LINE;
            S_D_LINE: state_next = S_D_A;
            S_D_A: begin
                if (vx_reg[2:0] != 3'd0) begin
                    state_next = S_D_BR;
                end else begin
                    state_next = row_last ? S_VFLAG : S_D_RD;
                end
            end
            S_D_BR: state_next = S_D_B;
            S_D_B:  state_next = row_last ? S_VFLAG : S_D_RD;
            S_FCLR: begin
                if (clr_reg[FRAME_AW-1:0] == FRAME_AW'(FRAME_BYTES - 1)) begin
                    state_next = S_FIN_F;
                end
            end
            S_MWR:      state_next = S_FIN_F;
            S_FRD:      state_next = S_FRD_WAIT;
            S_FRD_WAIT: state_next = S_FIN_F;
            S_FIN_F:    state_next = S_FIN_X;
            S_FIN_X:    state_next = S_FIN_W;
            S_FIN_W:    state_next = S_DONE;
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath controls and register updates for each sequencer step.
    always_comb begin
        pc_next      = pc_reg;
        i_next       = i_reg;
        sp_next      = sp_reg;
        dt_next      = dt_reg;
        st_next      = st_reg;
        clr_next     = clr_reg;
        m_valid_next = m_valid_reg;
        item_next    = item_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        line_next    = line_reg;
        flagv_next   = flagv_reg;
        tgt_next     = tgt_reg;
        rdata_next   = rdata_reg;
        base_next    = base_reg;
        cnt_next     = cnt_reg;
        hit_next     = hit_reg;
        aflag_next   = aflag_reg;
        status_next  = status_reg;
        res_next     = res_reg;

        gp_we  = 1'b0;
        gp_wa  = fx;
        gp_wd  = alu_y;
        gp_ra  = fx;
        stk_we = 1'b0;
        stk_wa = sp_reg[SAW-1:0];
        stk_wd = pc_inc;
        stk_ra = sp_dec[SAW-1:0];
        mem_we = 1'b0;
        mem_wa = mem_addr;
        mem_wd = 8'h00;
        mem_ra = mem_addr;
        frm_we = 1'b0;
        frm_wa = byte_a;
        frm_wd = alu_y;
        frm_ra = byte_a;
        alu_op = ALU_PASS;
        alu_a  = vx_reg;
        alu_b  = vy_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                frm_we   = (clr_reg < AW'(FRAME_BYTES));
                frm_wa   = clr_reg[FRAME_AW-1:0];
                frm_wd   = 8'h00;
                gp_we    = (clr_reg < AW'(NUM_GP));
                gp_wa    = clr_reg[3:0];
                gp_wd    = 8'h00;
                clr_next = clr_reg + AW'(1);
            end
            S_IDLE: begin
                if (s_valid) begin
                    item_next   = s_data;
                    rdata_next  = 8'h00;
                    status_next = (kind_t'(s_data.kind) == KIND_BAD) ? ST_UNSUP : ST_OK;
                end
            end
            S_RDX: gp_ra = fx;
            S_RDY: begin
                gp_ra   = (op_hi == OP_JP_V0) ? 4'd0 : fy;
                vx_next = gp_rd;
            end
            S_LATY: vy_next = gp_rd;
            S_DECODE: begin
                pc_next = pc_inc;
                unique case (op_hi)
                    OP_SYS: begin
                        if (is_cls) begin
                            clr_next = '0;
                        end else if (is_ret) begin
                            if (stack_empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                sp_next = sp_dec;
                            end
                        end else begin
                            status_next = ST_UNSUP;
                        end
                    end
                    OP_JP: pc_next = nnn;
                    OP_CALL: begin
                        if (stack_full) begin
                            status_next = ST_FULL;
                        end else begin
                            stk_we  = 1'b1;
                            sp_next = sp_reg + SPW'(1);
                            pc_next = nnn;
                        end
                    end
                    OP_SE_K:  pc_next = (vx_reg == kk) ? pc_skip : pc_inc;
                    OP_SNE_K: pc_next = (vx_reg != kk) ? pc_skip : pc_inc;
                    OP_SE_V:  pc_next = (vx_reg == vy_reg) ? pc_skip : pc_inc;
                    OP_SNE_V: pc_next = (vx_reg != vy_reg) ? pc_skip : pc_inc;
                    OP_LD_K: begin
                        alu_b = kk;
                        gp_we = 1'b1;
                    end
                    OP_ADD_K: begin
                        alu_op = ALU_ADD;
                        alu_b  = kk;
                        gp_we  = 1'b1;
                    end
                    OP_ALU: begin
                        case (fn)
                            N_MOV:   alu_op = ALU_PASS;
                            N_OR:    alu_op = ALU_OR;
                            N_AND:   alu_op = ALU_AND;
                            N_XOR:   alu_op = ALU_XOR;
                            N_ADD:   alu_op = ALU_ADD;
                            N_SUB:   alu_op = ALU_SUB;
                            N_SHR:   alu_op = ALU_SHR;
                            N_RSUB:  alu_op = ALU_RSUB;
                            N_SHL:   alu_op = ALU_SHL;
                            default: alu_op = ALU_PASS;
                        endcase
                        gp_we      = alu_ok;
                        aflag_next = alu_flag;
                        if (!alu_ok) begin
                            status_next = ST_UNSUP;
                        end
                    end
                    OP_LD_I:  i_next = {4'b0, nnn};
                    OP_JP_V0: pc_next = {4'b0, vy_reg} + nnn;
                    OP_RND: begin
                        alu_op = ALU_AND;
                        alu_a  = item_reg.random_byte;
                        alu_b  = kk;
                        gp_we  = 1'b1;
                    end
                    OP_DRW: begin
                        aflag_next = 1'b0;
                        cnt_next   = 4'd0;
                        hit_next   = 1'b0;
                        base_next  = {1'b0, i_reg};
                    end
                    OP_KEY: status_next = ST_UNSUP;
                    OP_MISC: begin
                        cnt_next  = 4'd0;
                        base_next = {1'b0, i_reg};
                        case (kk) inside
                            FX_GET_DT: begin
                                alu_b = dt_reg;
                                gp_we = 1'b1;
                            end
                            FX_SET_DT: dt_next = vx_reg;
                            FX_SET_ST: st_next = vx_reg;
                            FX_ADD_I:  i_next = i_reg + {8'b0, vx_reg};
                            FX_FONT:   i_next = FONT_BASE + {6'b0, vx_reg, 2'b0} + {8'b0, vx_reg};
                            FX_BCD, FX_STORE, FX_LOAD: ;
                            default:   status_next = ST_UNSUP;
                        endcase
                    end
                    default: status_next = ST_UNSUP;
                endcase
            end
            S_POP: pc_next = stk_rd;
            S_VFLAG: begin
                gp_we = 1'b1;
                gp_wa = FLAG_REG;
                gp_wd = {7'b0, aflag_reg};
            end
            S_IMOD: begin
                if (base_reg >= MEMW) begin
                    base_next = base_reg - MEMW;
                end
            end
            S_BCD: begin
                mem_we   = 1'b1;
                mem_wd   = bcd_digit(vx_reg, cnt_reg[1:0]);
                cnt_next = cnt_reg + 4'd1;
            end
            S_ST_RD: gp_ra = cnt_reg;
            S_ST_WR: begin
                mem_we   = 1'b1;
                mem_wd   = gp_rd;
                cnt_next = cnt_reg + 4'd1;
            end
            S_LD_RD: mem_ra = mem_addr;
            S_LD_WR: begin
                gp_we    = 1'b1;
                gp_wa    = cnt_reg;
                gp_wd    = mem_rd;
                cnt_next = cnt_reg + 4'd1;
            end
            S_D_RD: mem_ra = mem_addr;
            S_D_LINE: begin
                line_next = mem_rd;
                frm_ra    = byte_a;
            end
            S_D_A: begin
                alu_op   = ALU_XOR;
                alu_a    = frm_rd;
                alu_b    = frm_mask;
                frm_we   = 1'b1;
                frm_wa   = byte_a;
                hit_next = hit_now;
                if (vx_reg[2:0] == 3'd0) begin
                    aflag_next = hit_now;
                    cnt_next   = cnt_reg + 4'd1;
                end
            end
            S_D_BR: frm_ra = byte_b;
            S_D_B: begin
                alu_op     = ALU_XOR;
                alu_a      = frm_rd;
                alu_b      = frm_mask;
                frm_we     = 1'b1;
                frm_wa     = byte_b;
                hit_next   = hit_now;
                aflag_next = hit_now;
                cnt_next   = cnt_reg + 4'd1;
            end
            S_FCLR: begin
                frm_we   = 1'b1;
                frm_wa   = clr_reg[FRAME_AW-1:0];
                frm_wd   = 8'h00;
                clr_next = clr_reg + AW'(1);
            end
            S_MWR: begin
                mem_we = 1'b1;
                mem_wa = AW'(item_reg.address);
                mem_wd = item_reg.write_data;
            end
            S_FRD:      frm_ra = item_reg.address[FRAME_AW-1:0];
            S_FRD_WAIT: rdata_next = frm_rd;
            S_FIN_F:    gp_ra = FLAG_REG;
            S_FIN_X: begin
                gp_ra      = fx;
                flagv_next = gp_rd;
            end
            S_FIN_W: tgt_next = gp_rd;
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    res_next.program_counter = pc_reg;
                    res_next.index_value     = i_reg;
                    res_next.flag_value      = flagv_reg;
                    res_next.target_value    = tgt_reg;
                    res_next.delay_value     = dt_reg;
                    res_next.sound_value     = st_reg;
                    res_next.stack_level     = 5'(sp_reg);
                    res_next.read_data       = rdata_reg;
                    res_next.status          = status_reg;
                end
            end
            default: ;
        endcase
    end

    // Control registers; reset starts the clearing sweep.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            pc_reg      <= PC_RESET;
            i_reg       <= '0;
            sp_reg      <= '0;
            dt_reg      <= '0;
            st_reg      <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            i_reg       <= i_next;
            sp_reg      <= sp_next;
            dt_reg      <= dt_next;
            st_reg      <= st_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        line_reg   <= line_next;
        flagv_reg  <= flagv_next;
        tgt_reg    <= tgt_next;
        rdata_reg  <= rdata_next;
        base_reg   <= base_next;
        cnt_reg    <= cnt_next;
        hit_reg    <= hit_next;
        aflag_reg  <= aflag_next;
        status_reg <= status_next;
        res_reg    <= res_next;
    end

endmodule

`default_nettype wire
